// ===== hdl/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg: shared types and constants of the LOR to sinogram block
// Plane codes, the CORDIC arctangent table, the gain constant and the
// structs that travel down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

  // Plane codes of the plane_select register
  localparam logic [1:0] PLANE_XY   = 2'd0;
  localparam logic [1:0] PLANE_XZ   = 2'd1;
  localparam logic [1:0] PLANE_YZ   = 2'd2;
  localparam logic [1:0] PLANE_NONE = 2'd3;

  // Vector datapath and angle accumulator widths
  localparam int VecWidth = 64;
  localparam int AccWidth = 33;

  // Scale exponent of du and dv is (FixScale - COORD_WIDTH)
  localparam int FixScale = 60;

  // Inverse CORDIC gain in Q28
  localparam int GainWidth = 28;
  localparam logic [GainWidth-1:0] INV_GAIN_Q28 = 28'd163008219;

  // Angle output codes
  localparam logic [16:0] ANGLE_HALF = 17'd32768;
  localparam logic [16:0] ANGLE_FULL = 17'd65536;

  // atan(2^-i), 2^31 units per 180 degrees
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // Rotating vector and midpoint, plus the angle accumulator
  typedef struct packed {
    logic signed [VecWidth-1:0] x;
    logic signed [VecWidth-1:0] y;
    logic signed [VecWidth-1:0] px;
    logic signed [VecWidth-1:0] py;
    logic signed [AccWidth-1:0] acc;
  } lsc_vec_t;

  // Per-request case flags
  typedef struct packed {
    logic ok;    // result_valid of the request
    logic vert;  // du is zero: bypass the CORDIC result
    logic vpos;  // dv positive on a vertical line
  } lsc_flags_t;

endpackage

`default_nettype wire

// ===== hdl/lsc_prep.sv =====
// ----------------------------------------------------------------------------
// lsc_prep: plane selection, differences and midpoint scaling
// Two register stages: differences and sums first, then the shift of the
// direction vector and the multiplication of the midpoint by 1/K.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_prep
  import lsc_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_i,
  input  wire logic [1:0]                    plane_i,
  input  wire logic signed [COORD_WIDTH-1:0] first_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] first_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] first_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] second_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] second_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] second_z_i,
  output logic                               strobe_o,
  output lsc_vec_t                           vec_o,
  output lsc_flags_t                         flags_o,
  output logic signed [COORD_WIDTH:0]        rv_o
);

  localparam int DW    = COORD_WIDTH + 1;
  localparam int Shift = FixScale - COORD_WIDTH;
  localparam int PW    = COORD_WIDTH + GainWidth + 2;

  logic signed [COORD_WIDTH-1:0] a1, b1, a2, b2;
  logic signed [DW-1:0]          du_raw, dv_raw, du_c, dv_c, su_c, sv_c;
  logic signed [DW:0]            rv_wide;
  logic                          ok_c, vert_c, vpos_c;

  logic                          strobe_a_q;
  logic signed [DW-1:0]          du_q, dv_q, su_q, sv_q;
  lsc_flags_t                    flags_a_q;
  logic signed [COORD_WIDTH:0]   rv_a_q;

  logic signed [PW-1:0]          px_prod, py_prod;
  lsc_vec_t                      vec_d;

  // Pick the two axes of the projection plane
  always_comb begin
    case (plane_i)
      PLANE_XY: begin
        a1 = first_x_i;  b1 = first_y_i;  a2 = second_x_i; b2 = second_y_i;
      end
      PLANE_XZ: begin
        a1 = first_x_i;  b1 = first_z_i;  a2 = second_x_i; b2 = second_z_i;
      end
      default: begin
        a1 = first_y_i;  b1 = first_z_i;  a2 = second_y_i; b2 = second_z_i;
      end
    endcase
  end

  // Form differences and sums, fold negative du, classify the request
  always_comb begin
    du_raw = DW'(a2) - DW'(a1);
    dv_raw = DW'(b2) - DW'(b1);
    su_c   = DW'(a1) + DW'(a2);
    sv_c   = DW'(b1) + DW'(b2);
    ok_c   = (plane_i != PLANE_NONE) && !((du_raw == '0) && (dv_raw == '0));
    if (du_raw[DW-1]) begin
      du_c = -du_raw;
      dv_c = -dv_raw;
    end else begin
      du_c = du_raw;
      dv_c = dv_raw;
    end
    vert_c = (du_c == '0);
    vpos_c = !dv_c[DW-1] && (dv_c != '0);
    // Vertical line: r = -um for dv > 0, +um otherwise, rounded half up
    if (vpos_c) begin
      rv_wide = (DW+1)'(1) - (DW+1)'(su_c);
    end else begin
      rv_wide = (DW+1)'(su_c) + (DW+1)'(1);
    end
  end

  // Stage A: hold differences and sums of the accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_a_q <= 1'b0;
    end else begin
      strobe_a_q <= req_i;
    end
  end

  always_ff @(posedge clk_i) begin
    du_q           <= du_c;
    dv_q           <= dv_c;
    su_q           <= su_c;
    sv_q           <= sv_c;
    flags_a_q.ok   <= ok_c;
    flags_a_q.vert <= vert_c;
    flags_a_q.vpos <= vpos_c;
    rv_a_q         <= rv_wide[DW:1];
  end

  // Scale the direction vector and weight the midpoint sum by 1/K
  always_comb begin
    px_prod    = PW'(su_q) * $signed({2'b00, INV_GAIN_Q28});
    py_prod    = PW'(sv_q) * $signed({2'b00, INV_GAIN_Q28});
    vec_d.x    = VecWidth'(du_q) <<< Shift;
    vec_d.y    = VecWidth'(dv_q) <<< Shift;
    vec_d.px   = VecWidth'(px_prod);
    vec_d.py   = VecWidth'(py_prod);
    vec_d.acc  = '0;
  end

  // Stage B: hand the scaled vector to the first cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= strobe_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_o   <= vec_d;
    flags_o <= flags_a_q;
    rv_o    <= rv_a_q;
  end

endmodule

`default_nettype wire

// ===== hdl/lsc_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// lsc_cordic_cell: one vectoring micro-rotation
// Turns the direction vector toward the positive u axis by atan(2^-STAGE),
// turns the midpoint the same way and updates the angle accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_cordic_cell
  import lsc_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int STAGE       = 0
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        strobe_i,
  input  wire lsc_vec_t                    vec_i,
  input  wire lsc_flags_t                  flags_i,
  input  wire logic signed [COORD_WIDTH:0] rv_i,
  output logic                             strobe_o,
  output lsc_vec_t                         vec_o,
  output lsc_flags_t                       flags_o,
  output logic signed [COORD_WIDTH:0]      rv_o
);

  localparam logic signed [AccWidth-1:0] AtanStep =
    AccWidth'({1'b0, ATAN_TAB[STAGE]});

  logic signed [VecWidth-1:0] xs, ys, pxs, pys;
  lsc_vec_t                   vec_d;

  // Rotate by the sign of y
  always_comb begin
    xs  = $signed(vec_i.x)  >>> STAGE;
    ys  = $signed(vec_i.y)  >>> STAGE;
    pxs = $signed(vec_i.px) >>> STAGE;
    pys = $signed(vec_i.py) >>> STAGE;
    if (!vec_i.y[VecWidth-1]) begin
      vec_d.x   = vec_i.x  + ys;
      vec_d.y   = vec_i.y  - xs;
      vec_d.px  = vec_i.px + pys;
      vec_d.py  = vec_i.py - pxs;
      vec_d.acc = vec_i.acc + AtanStep;
    end else begin
      vec_d.x   = vec_i.x  - ys;
      vec_d.y   = vec_i.y  + xs;
      vec_d.px  = vec_i.px - pys;
      vec_d.py  = vec_i.py + pxs;
      vec_d.acc = vec_i.acc - AtanStep;
    end
  end

  // Advance the request strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= strobe_i;
    end
  end

  // Hand the rotated payload to the next cell
  always_ff @(posedge clk_i) begin
    vec_o   <= vec_d;
    flags_o <= flags_i;
    rv_o    <= rv_i;
  end

endmodule

`default_nettype wire

// ===== hdl/lsc_post.sv =====
// ----------------------------------------------------------------------------
// lsc_post: rounding, clamping and saturation of the result
// Rounds the accumulated angle and the rotated midpoint, selects the
// vertical-line bypass and registers the result ports.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_post
  import lsc_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          strobe_i,
  input  wire lsc_vec_t                      vec_i,
  input  wire lsc_flags_t                    flags_i,
  input  wire logic signed [COORD_WIDTH:0]   rv_i,
  output logic                               done_o,
  output logic signed [COORD_WIDTH-1:0]      radial_distance_o,
  output logic [16:0]                        projection_angle_o,
  output logic                               result_valid_o
);

  localparam int AW = 20;
  localparam logic signed [VecWidth-1:0] RHi =
    VecWidth'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [VecWidth-1:0] RLo = -RHi - VecWidth'(1);

  logic signed [AccWidth:0]     acc_rnd;
  logic signed [AW-1:0]         ang_full;
  logic signed [VecWidth-1:0]   r_rnd, r_sel;
  logic [16:0]                  ang_d;
  logic signed [COORD_WIDTH-1:0] r_d;

  // Round and clamp the angle, round and saturate the distance
  always_comb begin
    acc_rnd  = (AccWidth+1)'(vec_i.acc) + (AccWidth+1)'(16384);
    ang_full = AW'(ANGLE_HALF) + AW'(acc_rnd >>> 15);
    r_rnd    = (vec_i.py + (VecWidth'(1) <<< 28)) >>> 29;
    ang_d    = '0;
    r_d      = '0;
    if (flags_i.vert) begin
      r_sel = VecWidth'(rv_i);
      ang_d = flags_i.vpos ? ANGLE_FULL : '0;
    end else begin
      r_sel = r_rnd;
      if (ang_full[AW-1]) begin
        ang_d = '0;
      end else if (ang_full > AW'(ANGLE_FULL)) begin
        ang_d = ANGLE_FULL;
      end else begin
        ang_d = ang_full[16:0];
      end
    end
    if (r_sel > RHi) begin
      r_d = RHi[COORD_WIDTH-1:0];
    end else if (r_sel < RLo) begin
      r_d = RLo[COORD_WIDTH-1:0];
    end else begin
      r_d = r_sel[COORD_WIDTH-1:0];
    end
    // Drop the fields of an invalid request
    if (!flags_i.ok) begin
      r_d   = '0;
      ang_d = '0;
    end
  end

  // Strobe the result for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= strobe_i;
    end
  end

  always_ff @(posedge clk_i) begin
    radial_distance_o  <= r_d;
    projection_angle_o <= ang_d;
    result_valid_o     <= flags_i.ok;
  end

endmodule

`default_nettype wire

// ===== hdl/lor_to_sinogram_coordinates_top.sv =====
// ----------------------------------------------------------------------------
// lor_to_sinogram_coordinates_top: line of response to sinogram bin
// Projects a coincidence onto the configured plane and returns angle and
// signed radial distance through a chain of CORDIC cells.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   direction  handshake
//  request   start, busy, first_*_i, second_*_i        in         start & !busy
//  result    done_o, radial_distance_o,                out        done_o strobe
//            projection_angle_o, result_valid_o
//  config    cfg_we_i, cfg_wdata_i (plane_select)      in         cfg_we_i
//
//  A request is taken every cycle; busy stays low.
//  The stages in order: two preparation stages (differences, then the 1/K
//  multiplier), one cell per micro-rotation, one output stage.
//  Reset clears all strobes and sets plane_select to 1 (xz plane).
//  The result strobe is high for exactly one cycle; there is no stall.
// ----------------------------------------------------------------------------
`default_nettype none

module lor_to_sinogram_coordinates_top
  import lsc_pkg::*;
#(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] first_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] first_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] first_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] second_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] second_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] second_z_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_wdata_i,
  output logic                               done_o,
  output logic signed [COORD_WIDTH-1:0]      radial_distance_o,
  output logic [16:0]                        projection_angle_o,
  output logic                               result_valid_o
);

  logic [1:0]                  plane_q;
  logic                        req;

  logic                        strobe [CORDIC_STAGES+1];
  lsc_vec_t                    vec    [CORDIC_STAGES+1];
  lsc_flags_t                  flags  [CORDIC_STAGES+1];
  logic signed [COORD_WIDTH:0] rv     [CORDIC_STAGES+1];

  assign busy = 1'b0;
  assign req  = start && !busy;

  // Hold the plane selection register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= PLANE_XZ;
    end else if (cfg_we_i) begin
      plane_q <= cfg_wdata_i;
    end
  end

  // Prepare the direction vector and the scaled midpoint
  lsc_prep #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .plane_i    (plane_q),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .first_z_i  (first_z_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .second_z_i (second_z_i),
    .strobe_o   (strobe[0]),
    .vec_o      (vec[0]),
    .flags_o    (flags[0]),
    .rv_o       (rv[0])
  );

  // Chain one cell per micro-rotation
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    lsc_cordic_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .STAGE       (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .strobe_i (strobe[i]),
      .vec_i    (vec[i]),
      .flags_i  (flags[i]),
      .rv_i     (rv[i]),
      .strobe_o (strobe[i+1]),
      .vec_o    (vec[i+1]),
      .flags_o  (flags[i+1]),
      .rv_o     (rv[i+1])
    );
  end

  // Round, saturate and register the result
  lsc_post #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_post (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .strobe_i           (strobe[CORDIC_STAGES]),
    .vec_i              (vec[CORDIC_STAGES]),
    .flags_i            (flags[CORDIC_STAGES]),
    .rv_i               (rv[CORDIC_STAGES]),
    .done_o             (done_o),
    .radial_distance_o  (radial_distance_o),
    .projection_angle_o (projection_angle_o),
    .result_valid_o     (result_valid_o)
  );

endmodule

`default_nettype wire

// ===== hdl/lsc_checker.sv =====
// ----------------------------------------------------------------------------
// lsc_checker: port-level checks of the LOR to sinogram block
// Watches request-to-result latency and the legal range of result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_checker #(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done_o,
  input wire logic signed [COORD_WIDTH-1:0] radial_distance_o,
  input wire logic [16:0]                   projection_angle_o,
  input wire logic                          result_valid_o
);

  localparam int Latency = CORDIC_STAGES + 3;

  // Every accepted request yields a result after the fixed latency
  a_req_to_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done_o)
    else $error("result missing after request");

  // No result appears without a request
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##Latency !done_o)
    else $error("result without request");

  // Angle never exceeds 180 degrees
  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (projection_angle_o <= 17'd65536))
    else $error("projection angle out of range");

  // Invalid results carry zero fields
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_valid_o) |-> ((radial_distance_o == '0) &&
                                     (projection_angle_o == '0)))
    else $error("invalid result with nonzero fields");

endmodule

bind lor_to_sinogram_coordinates_top lsc_checker #(
  .COORD_WIDTH   (COORD_WIDTH),
  .CORDIC_STAGES (CORDIC_STAGES)
) u_lsc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start              (start),
  .busy               (busy),
  .done_o             (done_o),
  .radial_distance_o  (radial_distance_o),
  .projection_angle_o (projection_angle_o),
  .result_valid_o     (result_valid_o)
);

`default_nettype wire
